[rtl/sspr_pkg.sv]
// Shared types and constants for the servo status packet receiver.
// No dependencies; imported by the parser, the top level, the checker and the testbench.
`default_nettype none

package sspr_pkg;

   // Largest number of reply parameters (default of the top-level parameter)
   localparam int MAX_REPLY_PARAMS_DEF = 64;

   // Reset values of the timing registers
   localparam logic [15:0] BYTE_TIME_RST = 16'd210;
   localparam logic [15:0] MARGIN_RST    = 16'd5000;

   // Id that needs no reply
   localparam logic [7:0] BCAST_SERVO_ID = 8'd254;
   // Header byte, sent twice
   localparam logic [7:0] HEADER_BYTE  = 8'hFF;
   // Bytes of a reply beyond its parameters
   localparam logic [8:0] FRAME_OVERHEAD = 9'd6;

   localparam int TICK_W = 25;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   // Reported status
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_WAIT    = 3'd1,
      ST_SUCCESS = 3'd2,
      ST_CORRUPT = 3'd3,
      ST_TIMEOUT = 3'd4
   } status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_BYTE_TIME = 2'd0,
      CSR_MARGIN    = 2'd1
   } csr_index_type;

   // One request item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] expected_id;
      logic [7:0] reply_param_count;
      logic [7:0] rx_byte;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic [2:0] status;
      logic       done_res;
      logic [7:0] servo_error_bits;
      logic       param_valid;
      logic [5:0] param_index;
      logic [7:0] param_byte;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/sspr_ifs.sv]
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on nothing but plain logic types.
`default_nettype none

interface sspr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] expected_id;
   logic [7:0] reply_param_count;
   logic [7:0] rx_byte;
   modport source (output valid, kind, expected_id, reply_param_count, rx_byte, input ready);
   modport sink   (input valid, kind, expected_id, reply_param_count, rx_byte, output ready);
endinterface

interface sspr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       done_res;
   logic [7:0] servo_error_bits;
   logic       param_valid;
   logic [5:0] param_index;
   logic [7:0] param_byte;
   modport source (output valid, status, done_res, servo_error_bits, param_valid,
                   param_index, param_byte, input ready);
   modport sink   (input valid, status, done_res, servo_error_bits, param_valid,
                   param_index, param_byte, output ready);
endinterface

interface sspr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/sspr_parser.sv]
// Status packet parser: transaction state, header hunt, checksum and timeout.
// Depends on sspr_pkg. Updates its state on each step and returns that step's result.
`default_nettype none

module sspr_parser #(
   parameter int MAX_REPLY_PARAMS = sspr_pkg::MAX_REPLY_PARAMS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire sspr_pkg::req_item_type item,
   input  wire logic [15:0]            byte_time,
   input  wire logic [15:0]            margin,
   output sspr_pkg::rsp_item_type      result
);
   import sspr_pkg::*;

   // Largest legal length byte: parameters plus error/checksum overhead
   localparam logic [8:0] LEN_MAX  = 9'(MAX_REPLY_PARAMS + 2);
   localparam logic [TICK_W-1:0] TICK_SAT = {TICK_W{1'b1}};

   typedef enum logic [3:0] {
      PH_IDLE, PH_HUNT1, PH_HUNT2, PH_ID, PH_LEN, PH_ERR,
      PH_PARAM, PH_CSUM, PH_OK, PH_BAD, PH_TOUT
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [7:0]        want_id_ff, want_id_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [TICK_W-1:0] tick_limit_ff, tick_limit_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        left_ff, left_in;
   logic [5:0]        pos_ff, pos_in;
   logic              got_byte_ff, got_byte_in;
   logic [7:0]        err_ff, err_in;

   logic [8:0]        cnt_plus;
   logic [TICK_W-1:0] limit_prod;
   logic [TICK_W-1:0] limit_full;
   logic              waiting;
   logic              done;
   logic [7:0]        byte_sum;

   // Reply timeout: one multiply and one add, fits 25 bits for any register values
   assign cnt_plus   = {1'b0, item.reply_param_count} + FRAME_OVERHEAD;
   assign limit_prod = TICK_W'(byte_time) * TICK_W'(cnt_plus);
   assign limit_full = limit_prod + TICK_W'(margin);

   assign waiting  = (phase_ff >= PH_HUNT1) && (phase_ff <= PH_CSUM);
   assign byte_sum = sum_ff + item.rx_byte;

   // Next state and this step's result
   always_comb begin
      phase_in      = phase_ff;
      want_id_in    = want_id_ff;
      tick_count_in = tick_count_ff;
      tick_limit_in = tick_limit_ff;
      sum_in        = sum_ff;
      left_in       = left_ff;
      pos_in        = pos_ff;
      got_byte_in   = got_byte_ff;
      err_in        = err_ff;
      done          = 1'b0;
      result.param_valid = 1'b0;
      result.param_index = 6'd0;
      result.param_byte  = 8'd0;

      unique case (item.kind)
         KIND_START: begin
            want_id_in    = item.expected_id;
            tick_count_in = '0;
            sum_in        = 8'd0;
            left_in       = 8'd0;
            pos_in        = 6'd0;
            got_byte_in   = 1'b0;
            err_in        = 8'd0;
            if (item.expected_id == BCAST_SERVO_ID) begin
               tick_limit_in = '0;
               phase_in      = PH_OK;
               done          = 1'b1;
            end else begin
               tick_limit_in = limit_full;
               phase_in      = PH_HUNT1;
            end
         end
         KIND_BYTE: begin
            if (waiting) begin
               got_byte_in = 1'b1;
               unique case (phase_ff)
                  PH_HUNT1: begin
                     if (item.rx_byte == HEADER_BYTE) phase_in = PH_HUNT2;
                  end
                  PH_HUNT2: begin
                     phase_in = (item.rx_byte == HEADER_BYTE) ? PH_ID : PH_HUNT1;
                  end
                  PH_ID: begin
                     if (item.rx_byte != want_id_ff) begin
                        phase_in = PH_BAD;
                        done     = 1'b1;
                     end else begin
                        sum_in   = item.rx_byte;
                        phase_in = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     if (item.rx_byte < 8'd2 || {1'b0, item.rx_byte} > LEN_MAX) begin
                        phase_in = PH_BAD;
                        done     = 1'b1;
                     end else begin
                        sum_in   = byte_sum;
                        left_in  = item.rx_byte - 8'd2;
                        pos_in   = 6'd0;
                        phase_in = PH_ERR;
                     end
                  end
                  PH_ERR: begin
                     sum_in   = byte_sum;
                     err_in   = item.rx_byte;
                     phase_in = (left_ff == 8'd0) ? PH_CSUM : PH_PARAM;
                  end
                  PH_PARAM: begin
                     sum_in             = byte_sum;
                     result.param_valid = 1'b1;
                     result.param_index = pos_ff;
                     result.param_byte  = item.rx_byte;
                     pos_in             = pos_ff + 6'd1;
                     left_in            = left_ff - 8'd1;
                     if (left_ff == 8'd1) phase_in = PH_CSUM;
                  end
                  PH_CSUM: begin
                     phase_in = (item.rx_byte == ~sum_ff) ? PH_OK : PH_BAD;
                     done     = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         KIND_TICK: begin
            if (waiting) begin
               if (tick_count_ff != TICK_SAT) tick_count_in = tick_count_ff + TICK_W'(1);
               if (tick_count_in > tick_limit_ff) begin
                  phase_in = got_byte_ff ? PH_BAD : PH_TOUT;
                  done     = 1'b1;
               end
            end
         end
         default: begin
            // unused kind: nothing changes
         end
      endcase

      // Status follows the updated phase
      unique case (phase_in)
         PH_IDLE: result.status = ST_IDLE;
         PH_OK:   result.status = ST_SUCCESS;
         PH_BAD:  result.status = ST_CORRUPT;
         PH_TOUT: result.status = ST_TIMEOUT;
         default: result.status = ST_WAIT;
      endcase
      result.done_res         = done;
      result.servo_error_bits = (phase_in == PH_OK) ? err_in : 8'd0;
   end

   // Transaction state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         want_id_ff    <= 8'd0;
         tick_count_ff <= '0;
         tick_limit_ff <= '0;
         sum_ff        <= 8'd0;
         left_ff       <= 8'd0;
         pos_ff        <= 6'd0;
         got_byte_ff   <= 1'b0;
         err_ff        <= 8'd0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         want_id_ff    <= want_id_in;
         tick_count_ff <= tick_count_in;
         tick_limit_ff <= tick_limit_in;
         sum_ff        <= sum_in;
         left_ff       <= left_in;
         pos_ff        <= pos_in;
         got_byte_ff   <= got_byte_in;
         err_ff        <= err_in;
      end
   end

endmodule

`default_nettype wire

[rtl/servo_status_packet_receiver_core.sv]
// Top level of the servo status packet receiver: channels, registers, pipeline.
// Depends on sspr_pkg, the interfaces in sspr_ifs and sspr_parser.
`default_nettype none

// Receives a servo status reply one byte per request. A start request arms the
// receiver (broadcast id 254 succeeds at once); byte and tick requests then drive
// header hunt, id/length/error/parameter parsing, checksum and timeout. Every
// request yields exactly one result. Throughput is one request per clock while
// the result side keeps up: the request goes into an input register, the parser
// works on it combinationally and the result lands in an output register. The
// timing registers (index 0 byte time, index 1 margin) are written at any time
// over csr_ch, which is always ready, and take effect on the next start.
module servo_status_packet_receiver_core #(
   parameter int MAX_REPLY_PARAMS = sspr_pkg::MAX_REPLY_PARAMS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sspr_req_if.sink   req_ch,
   sspr_rsp_if.source rsp_ch,
   sspr_csr_if.sink   csr_ch
);
   import sspr_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type step_result;
   logic [15:0]  byte_time_ff;
   logic [15:0]  margin_ff;
   logic         advance;
   logic         req_fire;

   // Pipeline control: the input stage moves on when the output register is free or its result is taken
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire    = req_ch.valid && req_ch.ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.kind              <= req_ch.kind;
         in_item_ff.expected_id       <= req_ch.expected_id;
         in_item_ff.reply_param_count <= req_ch.reply_param_count;
         in_item_ff.rx_byte           <= req_ch.rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) out_item_ff <= step_result;
   end

   // Timing registers
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_time_ff <= BYTE_TIME_RST;
         margin_ff    <= MARGIN_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BYTE_TIME: byte_time_ff <= csr_ch.data;
            CSR_MARGIN:    margin_ff    <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   sspr_parser #(
      .MAX_REPLY_PARAMS (MAX_REPLY_PARAMS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .item      (in_item_ff),
      .byte_time (byte_time_ff),
      .margin    (margin_ff),
      .result    (step_result)
   );

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.status           = out_item_ff.status;
   assign rsp_ch.done_res         = out_item_ff.done_res;
   assign rsp_ch.servo_error_bits = out_item_ff.servo_error_bits;
   assign rsp_ch.param_valid      = out_item_ff.param_valid;
   assign rsp_ch.param_index      = out_item_ff.param_index;
   assign rsp_ch.param_byte       = out_item_ff.param_byte;

endmodule

`default_nettype wire

[rtl/sspr_checker.sv]
// Port-level checks of the servo status packet receiver, bound to the top level.
// Depends on sspr_pkg for status codes.
`default_nettype none

module sspr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] status,
   input wire logic       done_res,
   input wire logic [7:0] servo_error_bits,
   input wire logic       param_valid,
   input wire logic [5:0] param_index,
   input wire logic [7:0] param_byte
);
   import sspr_pkg::*;

   // A stalled result holds its status
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
      else $error("result changed while stalled");

   // The ending request reports a final outcome
   a_done_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |->
         status == ST_SUCCESS || status == ST_CORRUPT || status == ST_TIMEOUT)
      else $error("done without a final status");

   // Parameters only arrive mid-reply
   a_param_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && param_valid |-> status == ST_WAIT && !done_res)
      else $error("parameter outside a waiting reply");

   // Error bits only accompany success
   a_err_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && servo_error_bits != 8'd0 |-> status == ST_SUCCESS)
      else $error("error bits without success");

   // No parameter delivered means zero parameter fields
   a_param_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !param_valid |-> param_index == 6'd0 && param_byte == 8'd0)
      else $error("parameter fields set without a parameter");

endmodule

bind servo_status_packet_receiver_core sspr_checker u_sspr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .status           (rsp_ch.status),
   .done_res         (rsp_ch.done_res),
   .servo_error_bits (rsp_ch.servo_error_bits),
   .param_valid      (rsp_ch.param_valid),
   .param_index      (rsp_ch.param_index),
   .param_byte       (rsp_ch.param_byte)
);

`default_nettype wire

[verif/servo_status_packet_receiver_core_test.sv]
// Self-checking testbench for servo_status_packet_receiver_core: queued requests,
// a request-level receiver model and randomized valid/ready pressure on both channels.
// Depends on sspr_pkg, the channel interfaces in sspr_ifs and the core itself.
`timescale 1ns / 100ps

module servo_status_packet_receiver_core_test;
   import sspr_pkg::*;

   // Request kind that the receiver ignores
   localparam logic [1:0] KIND_VOID = 2'd3;
   localparam int MAX_PARAMS = MAX_REPLY_PARAMS_DEF;
   // Run is abandoned after this long
   localparam int RUN_LIMIT_NS = 5_000_000;

   // Receiver phases of the model
   typedef enum logic [3:0] {
      RX_IDLE, RX_SYNC1, RX_SYNC2, RX_ID, RX_LEN, RX_ERR, RX_PARAM, RX_CSUM,
      RX_OK, RX_BAD, RX_TOUT
   } rx_phase_type;

   // Ways a generated reply is spoiled
   typedef enum {FLAW_NONE, FLAW_ID, FLAW_LEN, FLAW_CSUM, FLAW_CUT} flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sspr_req_if req_bus ();
   sspr_rsp_if rsp_bus ();
   sspr_csr_if csr_bus ();

   servo_status_packet_receiver_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #5 clock = ~clock;

   // Stimulus and expectations
   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int           reqs_queued = 0;
   int           fail_count = 0;
   int           idle_odds = 0;   // 1-in-N chance of an idle burst, 0 for none

   // Model copy of the timing registers
   logic [15:0] cfg_byte_time = BYTE_TIME_RST;
   logic [15:0] cfg_margin    = MARGIN_RST;

   // Model copy of the receiver state
   rx_phase_type      m_phase    = RX_IDLE;
   logic [7:0]        m_want_id  = '0;
   logic [TICK_W-1:0] m_ticks    = '0;
   logic [TICK_W-1:0] m_limit    = '0;
   logic [7:0]        m_sum      = '0;
   logic [7:0]        m_left     = '0;
   logic [5:0]        m_pos      = '0;
   logic              m_heard    = 1'b0;
   logic [7:0]        m_err_hold = '0;

   // Advance the receiver model by one request and return the result it gives
   function automatic rsp_item_type step_receiver(input req_item_type r);
      rsp_item_type o;
      logic         done;
      logic         waiting;
      logic [31:0]  lim;
      logic [7:0]   b;
      o = '0;
      done = 1'b0;
      b = r.rx_byte;
      waiting = (m_phase >= RX_SYNC1) && (m_phase <= RX_CSUM);
      case (r.kind)
         KIND_START: begin
            m_want_id = r.expected_id;
            m_ticks = '0;
            m_sum = '0;
            m_left = '0;
            m_pos = '0;
            m_heard = 1'b0;
            m_err_hold = '0;
            if (r.expected_id == BCAST_SERVO_ID) begin
               m_limit = '0;
               m_phase = RX_OK;
               done = 1'b1;
            end else begin
               lim = 32'(cfg_byte_time) * (32'(r.reply_param_count) + 32'd6) + 32'(cfg_margin);
               m_limit = lim[TICK_W-1:0];
               m_phase = RX_SYNC1;
            end
         end
         KIND_BYTE: if (waiting) begin
            m_heard = 1'b1;
            case (m_phase)
               RX_SYNC1: if (b == HEADER_BYTE) m_phase = RX_SYNC2;
               RX_SYNC2: begin
                  if (b == HEADER_BYTE) m_phase = RX_ID;
                  else m_phase = RX_SYNC1;
               end
               RX_ID: begin
                  if (b != m_want_id) begin
                     m_phase = RX_BAD;
                     done = 1'b1;
                  end else begin
                     m_sum = b;
                     m_phase = RX_LEN;
                  end
               end
               RX_LEN: begin
                  if (int'(b) < 2 || int'(b) - 2 > MAX_PARAMS) begin
                     m_phase = RX_BAD;
                     done = 1'b1;
                  end else begin
                     m_sum = m_sum + b;
                     m_left = b - 8'd2;
                     m_pos = '0;
                     m_phase = RX_ERR;
                  end
               end
               RX_ERR: begin
                  m_sum = m_sum + b;
                  m_err_hold = b;
                  if (m_left == 8'd0) m_phase = RX_CSUM;
                  else m_phase = RX_PARAM;
               end
               RX_PARAM: begin
                  m_sum = m_sum + b;
                  o.param_valid = 1'b1;
                  o.param_index = m_pos;
                  o.param_byte = b;
                  m_pos = m_pos + 6'd1;
                  m_left = m_left - 8'd1;
                  if (m_left == 8'd0) m_phase = RX_CSUM;
               end
               RX_CSUM: begin
                  if (b == ~m_sum) m_phase = RX_OK;
                  else m_phase = RX_BAD;
                  done = 1'b1;
               end
               default: ;
            endcase
         end
         KIND_TICK: if (waiting) begin
            if (m_ticks != {TICK_W{1'b1}}) m_ticks = m_ticks + 1'b1;
            if (m_ticks > m_limit) begin
               if (m_heard) m_phase = RX_BAD;
               else m_phase = RX_TOUT;
               done = 1'b1;
            end
         end
         default: ;
      endcase
      case (m_phase)
         RX_IDLE: o.status = ST_IDLE;
         RX_OK:   o.status = ST_SUCCESS;
         RX_BAD:  o.status = ST_CORRUPT;
         RX_TOUT: o.status = ST_TIMEOUT;
         default: o.status = ST_WAIT;
      endcase
      o.done_res = done;
      o.servo_error_bits = (m_phase == RX_OK) ? m_err_hold : 8'd0;
      return o;
   endfunction

   task automatic note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Request queue helpers; fields a kind does not use get random values
   task automatic add_req(input logic [1:0] k, input logic [7:0] id, input logic [7:0] cnt,
                          input logic [7:0] b);
      req_item_type r;
      r.kind = k;
      r.expected_id = id;
      r.reply_param_count = cnt;
      r.rx_byte = b;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   task automatic add_start(input logic [7:0] id, input logic [7:0] cnt);
      add_req(KIND_START, id, cnt, 8'($urandom));
   endtask

   task automatic add_byte(input logic [7:0] b);
      add_req(KIND_BYTE, 8'($urandom), 8'($urandom), b);
   endtask

   task automatic add_tick();
      add_req(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // One reply frame, possibly spoiled, with a few ticks mixed in
   task automatic send_reply(input logic [7:0] id, input int nparams, input logic [7:0] errb,
                             input flaw_type flaw);
      logic [7:0] frame[$];
      logic [7:0] sum;
      logic [7:0] len;
      logic [7:0] b;
      int         n;
      frame.push_back(HEADER_BYTE);
      frame.push_back(HEADER_BYTE);
      if (flaw == FLAW_ID) begin
         frame.push_back(id + 8'($urandom_range(1, 255)));
      end else begin
         frame.push_back(id);
         if (flaw == FLAW_LEN) begin
            if ($urandom_range(0, 1) == 0) frame.push_back(8'($urandom_range(0, 1)));
            else frame.push_back(8'($urandom_range(MAX_PARAMS + 3, 255)));
         end else begin
            len = 8'(nparams + 2);
            frame.push_back(len);
            frame.push_back(errb);
            sum = id + len + errb;
            for (int i = 0; i < nparams; i++) begin
               b = ($urandom_range(0, 7) == 0) ? HEADER_BYTE : 8'($urandom);
               sum = sum + b;
               frame.push_back(b);
            end
            if (flaw == FLAW_CSUM) frame.push_back(~sum ^ 8'($urandom_range(1, 255)));
            else frame.push_back(~sum);
         end
      end
      n = frame.size();
      if (flaw == FLAW_CUT) n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) begin
         add_byte(frame[i]);
         if ($urandom_range(0, 5) == 0) add_tick();
      end
   endtask

   // One random transaction: mostly well-formed replies, some broken or timed out, some broadcasts, some noise
   task automatic gen_transaction();
      int         pick;
      int         nparams;
      int         lim;
      logic [7:0] id;
      logic [7:0] cnt;
      flaw_type   flaw;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
               0: add_byte(8'($urandom));
               1: add_tick();
               default: add_req(KIND_VOID, 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
         end
         return;
      end
      if (pick < 11) begin
         add_start(BCAST_SERVO_ID, 8'($urandom));
         return;
      end
      id = ($urandom_range(0, 19) == 0) ? 8'hFF : 8'($urandom_range(0, 253));
      nparams = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PARAMS) : $urandom_range(0, 8);
      cnt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(nparams);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // silent servo, or only stray bytes, then ticks that run the clock out when the limit is small
         cnt = 8'($urandom_range(0, 10));
         add_start(id, cnt);
         lim = int'(cfg_byte_time) * (int'(cnt) + 6) + int'(cfg_margin);
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 254)));
         end
         if (lim <= 400) repeat (lim + $urandom_range(1, 3)) add_tick();
         else repeat ($urandom_range(1, 20)) add_tick();
         return;
      end
      add_start(id, cnt);
      // line noise ahead of the header, sometimes with a lone header byte
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
         if ($urandom_range(0, 1) == 1) add_byte(HEADER_BYTE);
         add_byte(8'($urandom_range(0, 254)));
      end
      if (pick < 14) flaw = FLAW_ID;
      else if (pick < 20) flaw = FLAW_LEN;
      else if (pick < 28) flaw = FLAW_CSUM;
      else if (pick < 34) flaw = FLAW_CUT;
      else flaw = FLAW_NONE;
      send_reply(id, nparams, 8'($urandom), flaw);
   endtask

   // Register write; the model picks up the value when the write is taken
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_BYTE_TIME: cfg_byte_time = value;
         CSR_MARGIN:    cfg_margin = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Wait until every queued request has been answered, then let the pipe settle
   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_bus.valid);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input logic [15:0] byte_time, input logic [15:0] margin,
                            input int odds, input int count);
      int first;
      write_reg(CSR_BYTE_TIME, byte_time);
      write_reg(CSR_MARGIN, margin);
      idle_odds = odds;
      first = reqs_queued;
      while (reqs_queued - first < count) gen_transaction();
      drain();
   endtask

   // Request driver: presents the queue head, holds it until taken, idles in bursts
   int           req_gap = 0;
   req_item_type req_taken;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            req_taken = pending_reqs.pop_front();
            expected_rsps.push_back(step_receiver(req_taken));
         end
         if (req_bus.valid && !req_bus.ready) begin
            // held until taken
         end else if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            req_gap = $urandom_range(0, 11);
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid             <= 1'b1;
            req_bus.kind              <= pending_reqs[0].kind;
            req_bus.expected_id       <= pending_reqs[0].expected_id;
            req_bus.reply_param_count <= pending_reqs[0].reply_param_count;
            req_bus.rx_byte           <= pending_reqs[0].rx_byte;
         end
      end
   end

   // Result monitor: checks each result against the oldest expectation, stalls in bursts
   int           rsp_stall = 0;
   rsp_item_type rsp_seen;
   rsp_item_type rsp_want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen.status           = rsp_bus.status;
            rsp_seen.done_res         = rsp_bus.done_res;
            rsp_seen.servo_error_bits = rsp_bus.servo_error_bits;
            rsp_seen.param_valid      = rsp_bus.param_valid;
            rsp_seen.param_index      = rsp_bus.param_index;
            rsp_seen.param_byte       = rsp_bus.param_byte;
            if (expected_rsps.size() == 0) begin
               note_fail($sformatf("unexpected result: status %0d done %0d err %02h pv %0d idx %0d byte %02h",
                  rsp_seen.status, rsp_seen.done_res, rsp_seen.servo_error_bits,
                  rsp_seen.param_valid, rsp_seen.param_index, rsp_seen.param_byte));
            end else begin
               rsp_want = expected_rsps.pop_front();
               if (rsp_seen.status !== rsp_want.status ||
                   rsp_seen.done_res !== rsp_want.done_res ||
                   rsp_seen.servo_error_bits !== rsp_want.servo_error_bits ||
                   rsp_seen.param_valid !== rsp_want.param_valid ||
                   rsp_seen.param_index !== rsp_want.param_index ||
                   rsp_seen.param_byte !== rsp_want.param_byte) begin
                  note_fail($sformatf({"result mismatch at %0t: expected status %0d done %0d err %02h",
                     " pv %0d idx %0d byte %02h, got status %0d done %0d err %02h pv %0d idx %0d",
                     " byte %02h"}, $realtime,
                     rsp_want.status, rsp_want.done_res, rsp_want.servo_error_bits,
                     rsp_want.param_valid, rsp_want.param_index, rsp_want.param_byte,
                     rsp_seen.status, rsp_seen.done_res, rsp_seen.servo_error_bits,
                     rsp_seen.param_valid, rsp_seen.param_index, rsp_seen.param_byte));
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_stall = $urandom_range(0, 11);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Overall time limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   // Sequence of the run
   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_TICK;
      req_bus.expected_id = '0;
      req_bus.reply_param_count = '0;
      req_bus.rx_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_BYTE_TIME;
      csr_bus.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset timing, ignored requests, broadcast, rearm, header hunt
      idle_odds = 4;
      add_tick();
      add_byte(8'h00);
      add_req(KIND_VOID, 8'hFF, 8'hFF, 8'hFF);
      add_start(BCAST_SERVO_ID, 8'd0);
      add_start(8'd1, 8'd2);
      add_start(8'hFF, 8'd255);
      add_byte(8'h00);
      add_byte(HEADER_BYTE);
      add_byte(8'h12);
      add_byte(HEADER_BYTE);
      add_byte(HEADER_BYTE);
      add_byte(8'hFF);
      add_byte(8'd3);
      add_byte(8'h80);
      add_byte(8'hFF);
      add_byte(8'(~(8'hFF + 8'd3 + 8'h80 + 8'hFF)));
      add_byte(8'h55);
      add_tick();
      // wrong id in the reply
      add_start(8'd0, 8'd0);
      add_byte(HEADER_BYTE);
      add_byte(HEADER_BYTE);
      add_byte(8'd7);
      drain();

      // directed: shortest timeout with no byte heard
      write_reg(CSR_BYTE_TIME, 16'd1);
      write_reg(CSR_MARGIN, 16'd0);
      add_start(8'd5, 8'd0);
      repeat (7) add_tick();
      drain();

      // random phases across timing settings; the last one runs without idling
      run_phase(16'd1, 16'd0, 6, 290);
      run_phase(16'hFFFF, 16'hFFFF, 3, 290);
      run_phase(16'd2, 16'd5, 8, 290);
      run_phase(16'($urandom_range(1, 65535)), 16'($urandom), 5, 290);
      run_phase(BYTE_TIME_RST, MARGIN_RST, 10, 290);
      run_phase(16'($urandom_range(1, 3)), 16'($urandom_range(0, 40)), 0, 290);

      repeat (10) @(negedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
